### sv/assert_macros.svh
// assertion macros used by the mapper core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant violated");

// expression never holds
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

### sv/lcbm_pkg.sv
// types and constants of the latched chr bank mapper
`timescale 1ns / 1ps

package lcbm_pkg;

    // bank number, count, delay, offset and index widths
    localparam int BANK_W       = 8;
    localparam int COUNT_W      = 9;
    localparam int DELAY_W      = 8;
    localparam int PRG_OFS_W    = 14;
    localparam int CHR_OFS_W    = 12;
    localparam int ROM_OFS_W    = 22;
    localparam int CFG_IDX_W    = 2;

    typedef logic [BANK_W-1:0]  t_bank;
    typedef logic [COUNT_W-1:0] t_count;

    // operation codes
    localparam logic [1:0] OP_CPU_WRITE = 2'd0;
    localparam logic [1:0] OP_CPU_READ  = 2'd1;
    localparam logic [1:0] OP_PPU_READ  = 2'd2;

    // cpu write decode by address top nibble
    localparam logic [3:0] NIB_PRG    = 4'hA;
    localparam logic [3:0] NIB_CHR0   = 4'hB;
    localparam logic [3:0] NIB_CHR1   = 4'hC;
    localparam logic [3:0] NIB_CHR2   = 4'hD;
    localparam logic [3:0] NIB_CHR3   = 4'hE;
    localparam logic [3:0] NIB_MIRROR = 4'hF;

    // latch trigger tiles, ppu address bits 12:4
    localparam logic [8:0] TILE_LOWER_FD = 9'h0FD;
    localparam logic [8:0] TILE_LOWER_FE = 9'h0FE;
    localparam logic [8:0] TILE_UPPER_FD = 9'h1FD;
    localparam logic [8:0] TILE_UPPER_FE = 9'h1FE;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_MIRROR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_DELAY = 2'd3;

    // configuration reset values
    localparam t_count              RST_PRG_COUNT   = 9'd8;
    localparam t_count              RST_CHR_COUNT   = 9'd16;
    localparam logic [DELAY_W-1:0]  RST_UPPER_DELAY = 8'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in_item;

    typedef struct packed {
        logic [ROM_OFS_W-1:0] rom_offset;
        logic                 mirroring_horizontal;
        logic                 mirroring_changed;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [COUNT_W-1:0]   wdata;
    } t_cfg_write;

    // status of the shared modulo unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_status;

    // bank count of zero acts as one, above 256 acts as 256
    function automatic t_count clamp_count(input t_count c);
        t_count r;
        if (c == '0) begin
            r = 9'd1;
        end else if (c > 9'd256) begin
            r = 9'd256;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

### sv/lcbm_stream_if.sv
// valid/ready channel carrying one payload struct
`timescale 1ns / 1ps

interface lcbm_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/lcbm_mod_unit.sv
// iterative restoring modulo unit, one dividend bit per cycle
`timescale 1ns / 1ps

module lcbm_mod_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  lcbm_pkg::t_bank      i_dividend,
    input  lcbm_pkg::t_count     i_divisor,
    output lcbm_pkg::t_mod_status o_status,
    output lcbm_pkg::t_bank      o_remainder
);
    localparam int STEP_W = $clog2(lcbm_pkg::BANK_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(lcbm_pkg::BANK_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    lcbm_pkg::t_bank   r_dividend;
    lcbm_pkg::t_count  r_divisor;
    lcbm_pkg::t_bank   r_rem;

    logic [lcbm_pkg::COUNT_W-1:0] shifted;
    logic [lcbm_pkg::COUNT_W-1:0] diff;
    lcbm_pkg::t_bank              n_rem;

    // one shift, compare and subtract step
    always_comb begin
        shifted = {r_rem, r_dividend[lcbm_pkg::BANK_W-1]};
        diff    = shifted - r_divisor;
        if (shifted >= r_divisor) begin
            n_rem = diff[lcbm_pkg::BANK_W-1:0];
        end else begin
            n_rem = shifted[lcbm_pkg::BANK_W-1:0];
        end
    end

    // step counter and handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= LAST_STEP;
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= i_dividend;
            r_divisor  <= i_divisor;
            r_rem      <= '0;
        end else if (r_busy) begin
            r_dividend <= {r_dividend[lcbm_pkg::BANK_W-2:0], 1'b0};
            r_rem      <= n_rem;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_remainder   = r_rem;

endmodule

### sv/latched_chr_bank_mapper_core.sv
// top level of the latched chr bank mapper
//
// Usage: i_in takes one access per transaction (cpu write, cpu read or ppu
// pattern read); o_out returns exactly one transaction for each, carrying the
// rom byte offset the access selects and the current mirroring. i_cfg writes
// the bank counts, header mirroring and upper switch delay; it is ready out
// of reset and must only be used while no access is in flight.
// Timing: bank register writes ($A000-$EFFF) and cpu reads of $8000-$BFFF
// reduce a bank number modulo the bank count in a shared one-bit-per-cycle
// modulo unit, so such an access goes from idle through the divide state to
// finish; all other accesses go from idle straight to finish.
// i_in is not ready while an access is being worked on or during reset.
// A finished result sits in an output register; the next access is accepted
// while it waits, but that access is held before commit until the receiver
// takes the previous result, so a stalled receiver stalls the block.
// Reset: synchronous, active low; latches, banks, mirroring state and the
// switch countdown clear to zero and the configuration returns to its
// defaults (8 program banks, 16 pattern banks, vertical, delay of 1).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module latched_chr_bank_mapper_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lcbm_stream_if.sink        i_in,
    lcbm_stream_if.source      o_out,
    lcbm_stream_if.sink        i_cfg
);
    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // configuration
    lcbm_pkg::t_count                r_prg_count;
    lcbm_pkg::t_count                r_chr_count;
    logic                            r_hdr_mirror;
    logic [lcbm_pkg::DELAY_W-1:0]    r_sw_delay;

    // mapper state
    logic                            r_lower_latch,  n_lower_latch;
    logic                            r_upper_latch,  n_upper_latch;
    lcbm_pkg::t_bank                 r_lower_active, n_lower_active;
    lcbm_pkg::t_bank                 r_upper_active, n_upper_active;
    lcbm_pkg::t_bank                 r_chr_bank [4];
    lcbm_pkg::t_bank                 n_chr_bank [4];
    lcbm_pkg::t_bank                 r_prg_bank,     n_prg_bank;
    logic                            r_mirror,       n_mirror;
    logic                            r_mirror_wr,    n_mirror_wr;
    logic [lcbm_pkg::DELAY_W-1:0]    r_countdown,    n_countdown;
    logic                            r_pending,      n_pending;

    // sequencer and item registers
    logic [1:0]                      r_state, n_state;
    lcbm_pkg::t_in_item              r_item;
    lcbm_pkg::t_out_item             r_out, n_out;
    logic                            r_out_valid;

    // shared modulo unit
    lcbm_pkg::t_mod_status           mod_status;
    lcbm_pkg::t_bank                 mod_rem;
    logic                            mod_start;
    lcbm_pkg::t_bank                 mod_dividend;
    lcbm_pkg::t_count                mod_divisor;

    logic                            in_accept;
    logic                            in_needs_mod;
    logic                            in_chr_write;
    logic                            out_free;
    logic                            commit;
    lcbm_pkg::t_count                prg_eff;
    lcbm_pkg::t_count                chr_eff;
    lcbm_pkg::t_count                prg_last;
    logic [lcbm_pkg::DELAY_W-1:0]    delay_eff;
    logic [3:0]                      nib;
    logic [8:0]                      tile;
    logic [lcbm_pkg::DELAY_W-1:0]    cnt_armed;

    assign prg_eff   = lcbm_pkg::clamp_count(r_prg_count);
    assign chr_eff   = lcbm_pkg::clamp_count(r_chr_count);
    assign prg_last  = prg_eff - 9'd1;
    assign delay_eff = (r_sw_delay == '0) ? lcbm_pkg::DELAY_W'(1) : r_sw_delay;

    assign i_in.ready  = i_rst_n && (r_state == ST_IDLE);
    assign i_cfg.ready = i_rst_n;
    assign in_accept   = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign commit      = (r_state == ST_FIN) && out_free;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // decide whether the incoming transaction needs a modulo
    always_comb begin
        in_needs_mod = 1'b0;
        in_chr_write = 1'b0;
        case (i_in.data.op)
            lcbm_pkg::OP_CPU_WRITE: begin
                case (i_in.data.address[15:12]) inside
                    lcbm_pkg::NIB_PRG: begin
                        in_needs_mod = 1'b1;
                    end
                    lcbm_pkg::NIB_CHR0, lcbm_pkg::NIB_CHR1,
                    lcbm_pkg::NIB_CHR2, lcbm_pkg::NIB_CHR3: begin
                        in_needs_mod = 1'b1;
                        in_chr_write = 1'b1;
                    end
                    default: ;
                endcase
            end
            lcbm_pkg::OP_CPU_READ: begin
                in_needs_mod = (i_in.data.address[15:14] == 2'b10);
            end
            default: ;
        endcase
    end

    // modulo operands: written byte or stored program bank
    assign mod_start    = in_accept && in_needs_mod;
    assign mod_dividend = (i_in.data.op == lcbm_pkg::OP_CPU_WRITE) ? i_in.data.data
                                                                   : r_prg_bank;
    assign mod_divisor  = in_chr_write ? chr_eff : prg_eff;

    lcbm_mod_unit u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (mod_start),
        .i_dividend  (mod_dividend),
        .i_divisor   (mod_divisor),
        .o_status    (mod_status),
        .o_remainder (mod_rem)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = in_needs_mod ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV: begin
                if (mod_status.done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // next mapper state and result for the held transaction
    always_comb begin
        n_lower_latch  = r_lower_latch;
        n_upper_latch  = r_upper_latch;
        n_lower_active = r_lower_active;
        n_upper_active = r_upper_active;
        n_chr_bank     = r_chr_bank;
        n_prg_bank     = r_prg_bank;
        n_mirror       = r_mirror;
        n_mirror_wr    = r_mirror_wr;
        n_countdown    = r_countdown;
        n_pending      = r_pending;
        n_out          = '0;
        cnt_armed      = r_countdown;
        nib            = r_item.address[15:12];
        tile           = r_item.address[12:4];

        case (r_item.op)
            lcbm_pkg::OP_CPU_WRITE: begin
                unique case (nib)
                    lcbm_pkg::NIB_PRG: begin
                        n_prg_bank = mod_rem;
                    end
                    lcbm_pkg::NIB_CHR0: begin
                        n_chr_bank[0] = mod_rem;
                        if (!r_lower_latch) n_lower_active = mod_rem;
                    end
                    lcbm_pkg::NIB_CHR1: begin
                        n_chr_bank[1] = mod_rem;
                        if (r_lower_latch) n_lower_active = mod_rem;
                    end
                    lcbm_pkg::NIB_CHR2: begin
                        n_chr_bank[2] = mod_rem;
                        if (!r_upper_latch) n_upper_active = mod_rem;
                    end
                    lcbm_pkg::NIB_CHR3: begin
                        n_chr_bank[3] = mod_rem;
                        if (r_upper_latch) n_upper_active = mod_rem;
                    end
                    lcbm_pkg::NIB_MIRROR: begin
                        n_mirror                = r_item.data[0];
                        n_mirror_wr             = 1'b1;
                        n_out.mirroring_changed = 1'b1;
                    end
                    default: ;
                endcase
            end
            lcbm_pkg::OP_CPU_READ: begin
                // switchable window, then fixed last bank
                if (r_item.address[15]) begin
                    if (!r_item.address[14]) begin
                        n_out.rom_offset = {mod_rem, r_item.address[13:0]};
                    end else begin
                        n_out.rom_offset = {prg_last[lcbm_pkg::BANK_W-1:0],
                                            r_item.address[13:0]};
                    end
                end
            end
            lcbm_pkg::OP_PPU_READ: begin
                // latch test first, lower switch shows in this read
                if (tile == lcbm_pkg::TILE_LOWER_FD && r_lower_latch) begin
                    n_lower_latch  = 1'b0;
                    n_lower_active = r_chr_bank[0];
                end else if (tile == lcbm_pkg::TILE_LOWER_FE && !r_lower_latch) begin
                    n_lower_latch  = 1'b1;
                    n_lower_active = r_chr_bank[1];
                end else if (tile == lcbm_pkg::TILE_UPPER_FD && r_upper_latch) begin
                    n_upper_latch = 1'b0;
                    cnt_armed     = delay_eff;
                    n_pending     = 1'b0;
                end else if (tile == lcbm_pkg::TILE_UPPER_FE && !r_upper_latch) begin
                    n_upper_latch = 1'b1;
                    cnt_armed     = delay_eff;
                    n_pending     = 1'b1;
                end
                if (r_item.address[12]) begin
                    n_out.rom_offset = {2'b00, r_upper_active, r_item.address[11:0]};
                end else begin
                    n_out.rom_offset = {2'b00, n_lower_active, r_item.address[11:0]};
                end
                // delayed upper switch counts pattern reads
                n_countdown = cnt_armed;
                if (cnt_armed != '0) begin
                    n_countdown = cnt_armed - 1'b1;
                    if (cnt_armed == lcbm_pkg::DELAY_W'(1)) begin
                        n_upper_active = r_chr_bank[{1'b1, n_pending}];
                    end
                end
            end
            default: ;
        endcase

        n_out.mirroring_horizontal = n_mirror_wr ? n_mirror : r_hdr_mirror;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count  <= lcbm_pkg::RST_PRG_COUNT;
            r_chr_count  <= lcbm_pkg::RST_CHR_COUNT;
            r_hdr_mirror <= 1'b0;
            r_sw_delay   <= lcbm_pkg::RST_UPPER_DELAY;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.data.reg_index)
                lcbm_pkg::CFG_PRG_COUNT:   r_prg_count  <= i_cfg.data.wdata;
                lcbm_pkg::CFG_CHR_COUNT:   r_chr_count  <= i_cfg.data.wdata;
                lcbm_pkg::CFG_HDR_MIRROR:  r_hdr_mirror <= i_cfg.data.wdata[0];
                lcbm_pkg::CFG_UPPER_DELAY: r_sw_delay   <= i_cfg.data.wdata[lcbm_pkg::DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, mapper state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_lower_latch  <= 1'b0;
            r_upper_latch  <= 1'b0;
            r_lower_active <= '0;
            r_upper_active <= '0;
            r_chr_bank     <= '{default: '0};
            r_prg_bank     <= '0;
            r_mirror       <= 1'b0;
            r_mirror_wr    <= 1'b0;
            r_countdown    <= '0;
            r_pending      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid    <= 1'b1;
                r_lower_latch  <= n_lower_latch;
                r_upper_latch  <= n_upper_latch;
                r_lower_active <= n_lower_active;
                r_upper_active <= n_upper_active;
                r_chr_bank     <= n_chr_bank;
                r_prg_bank     <= n_prg_bank;
                r_mirror       <= n_mirror;
                r_mirror_wr    <= n_mirror_wr;
                r_countdown    <= n_countdown;
                r_pending      <= n_pending;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction payload and result registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in.data;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    // checks
    `ASSERT_NEVER(a_no_accept_while_busy, i_clk, i_rst_n, i_in.ready && mod_status.busy)
    `ASSERT_NEVER(a_done_only_in_div, i_clk, i_rst_n, mod_status.done && (r_state != ST_DIV))
    `ASSERT_ALWAYS(a_lower_follows_latch, i_clk, i_rst_n, r_lower_active == r_chr_bank[{1'b0, r_lower_latch}])
    `ASSERT_IMPLY(a_changed_has_no_offset, i_clk, i_rst_n, r_out_valid && r_out.mirroring_changed, r_out.rom_offset == '0)

endmodule

### tb/lcbm_mapper_checker.sv
// checker for the latched chr bank mapper: predicts every result and compares it
`timescale 1ns / 1ps

module lcbm_mapper_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  lcbm_pkg::t_in_item   i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  lcbm_pkg::t_out_item  i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  lcbm_pkg::t_cfg_write i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // configuration as the block should hold it
    logic [lcbm_pkg::COUNT_W-1:0] prg_count;
    logic [lcbm_pkg::COUNT_W-1:0] chr_count;
    logic                         hdr_mirror;
    logic [lcbm_pkg::DELAY_W-1:0] upper_delay;

    // mapper state
    logic                         lower_latch;
    logic                         upper_latch;
    logic [lcbm_pkg::BANK_W-1:0]  lower_active;
    logic [lcbm_pkg::BANK_W-1:0]  upper_active;
    logic [lcbm_pkg::BANK_W-1:0]  chr_regs [4];
    logic [lcbm_pkg::BANK_W-1:0]  prg_bank;
    logic                         mirror_reg;
    logic                         mirror_written;
    logic [lcbm_pkg::DELAY_W-1:0] countdown;
    logic                         pend_idx;

    lcbm_pkg::t_out_item pending_results [$];
    int                  mismatches;

    // zero counts act as one, counts above 256 act as 256
    function automatic logic [lcbm_pkg::COUNT_W-1:0] bank_limit(
        input logic [lcbm_pkg::COUNT_W-1:0] c);
        if (c == 9'd0) return 9'd1;
        if (c > 9'd256) return 9'd256;
        return c;
    endfunction

    function automatic logic [lcbm_pkg::BANK_W-1:0] mod_bank(
        input logic [7:0] v, input logic [lcbm_pkg::COUNT_W-1:0] lim);
        logic [lcbm_pkg::COUNT_W-1:0] r;
        r = {1'b0, v} % lim;
        return r[lcbm_pkg::BANK_W-1:0];
    endfunction

    task automatic reset_model();
        prg_count      = lcbm_pkg::RST_PRG_COUNT;
        chr_count      = lcbm_pkg::RST_CHR_COUNT;
        hdr_mirror     = 1'b0;
        upper_delay    = lcbm_pkg::RST_UPPER_DELAY;
        lower_latch    = 1'b0;
        upper_latch    = 1'b0;
        lower_active   = '0;
        upper_active   = '0;
        for (int i = 0; i < 4; i++) chr_regs[i] = '0;
        prg_bank       = '0;
        mirror_reg     = 1'b0;
        mirror_written = 1'b0;
        countdown      = '0;
        pend_idx       = 1'b0;
    endtask

    task automatic arm_upper_switch(input logic idx);
        countdown = (upper_delay == '0) ? 8'd1 : upper_delay;
        pend_idx  = idx;
    endtask

    // one access: update state and form the result
    task automatic map_access(input lcbm_pkg::t_in_item acc, output lcbm_pkg::t_out_item res);
        logic [lcbm_pkg::COUNT_W-1:0]   prg_lim;
        logic [lcbm_pkg::COUNT_W-1:0]   chr_lim;
        logic [8:0]                     tile;
        logic [lcbm_pkg::BANK_W-1:0]    bank;
        logic [lcbm_pkg::ROM_OFS_W-1:0] ofs;
        logic                           changed;
        prg_lim = bank_limit(prg_count);
        chr_lim = bank_limit(chr_count);
        ofs     = '0;
        changed = 1'b0;
        case (acc.op)
            lcbm_pkg::OP_CPU_WRITE: begin
                case (acc.address[15:12])
                    lcbm_pkg::NIB_PRG: prg_bank = mod_bank(acc.data, prg_lim);
                    lcbm_pkg::NIB_CHR0: begin
                        chr_regs[0] = mod_bank(acc.data, chr_lim);
                        if (!lower_latch) lower_active = chr_regs[0];
                    end
                    lcbm_pkg::NIB_CHR1: begin
                        chr_regs[1] = mod_bank(acc.data, chr_lim);
                        if (lower_latch) lower_active = chr_regs[1];
                    end
                    lcbm_pkg::NIB_CHR2: begin
                        chr_regs[2] = mod_bank(acc.data, chr_lim);
                        if (!upper_latch) upper_active = chr_regs[2];
                    end
                    lcbm_pkg::NIB_CHR3: begin
                        chr_regs[3] = mod_bank(acc.data, chr_lim);
                        if (upper_latch) upper_active = chr_regs[3];
                    end
                    lcbm_pkg::NIB_MIRROR: begin
                        mirror_reg     = acc.data[0];
                        mirror_written = 1'b1;
                        changed        = 1'b1;
                    end
                    default: ;
                endcase
            end
            lcbm_pkg::OP_CPU_READ: begin
                if (acc.address[15]) begin
                    if (acc.address < 16'hC000) bank = mod_bank(prg_bank, prg_lim);
                    else bank = 8'(prg_lim - 9'd1);
                    ofs = {bank, acc.address[13:0]};
                end
            end
            lcbm_pkg::OP_PPU_READ: begin
                // latch test first, so a lower switch applies to this read
                tile = acc.address[12:4];
                if (tile == lcbm_pkg::TILE_LOWER_FD && lower_latch) begin
                    lower_latch  = 1'b0;
                    lower_active = chr_regs[0];
                end else if (tile == lcbm_pkg::TILE_LOWER_FE && !lower_latch) begin
                    lower_latch  = 1'b1;
                    lower_active = chr_regs[1];
                end else if (tile == lcbm_pkg::TILE_UPPER_FD && upper_latch) begin
                    upper_latch = 1'b0;
                    arm_upper_switch(1'b0);
                end else if (tile == lcbm_pkg::TILE_UPPER_FE && !upper_latch) begin
                    upper_latch = 1'b1;
                    arm_upper_switch(1'b1);
                end
                bank = acc.address[12] ? upper_active : lower_active;
                ofs  = {2'b00, bank, acc.address[11:0]};
                // delayed upper switch counts pattern reads
                if (countdown != '0) begin
                    countdown = countdown - 8'd1;
                    if (countdown == '0) upper_active = chr_regs[{1'b1, pend_idx}];
                end
            end
            default: ;
        endcase
        res.rom_offset           = ofs;
        res.mirroring_horizontal = mirror_written ? mirror_reg : hdr_mirror;
        res.mirroring_changed    = changed;
    endtask

    task automatic apply_reg_write(input lcbm_pkg::t_cfg_write w);
        case (w.reg_index)
            lcbm_pkg::CFG_PRG_COUNT:   prg_count   = w.wdata;
            lcbm_pkg::CFG_CHR_COUNT:   chr_count   = w.wdata;
            lcbm_pkg::CFG_HDR_MIRROR:  hdr_mirror  = w.wdata[0];
            lcbm_pkg::CFG_UPPER_DELAY: upper_delay = w.wdata[lcbm_pkg::DELAY_W-1:0];
            default: ;
        endcase
    endtask

    // result compare, register writes and prediction on each edge
    always @(posedge i_clk) begin : watch
        lcbm_pkg::t_out_item want;
        lcbm_pkg::t_out_item oldest;
        if (!i_rst_n) begin
            reset_model();
            pending_results.delete();
            mismatches = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with no access outstanding, rom_offset %0h",
                             $time, i_out_data.rom_offset);
                    mismatches++;
                end else begin
                    oldest = pending_results.pop_front();
                    if (i_out_data.rom_offset !== oldest.rom_offset) begin
                        $display("%0t: rom_offset expected %0h actual %0h",
                                 $time, oldest.rom_offset, i_out_data.rom_offset);
                        mismatches++;
                    end
                    if (i_out_data.mirroring_horizontal !== oldest.mirroring_horizontal) begin
                        $display("%0t: mirroring_horizontal expected %0b actual %0b",
                                 $time, oldest.mirroring_horizontal,
                                 i_out_data.mirroring_horizontal);
                        mismatches++;
                    end
                    if (i_out_data.mirroring_changed !== oldest.mirroring_changed) begin
                        $display("%0t: mirroring_changed expected %0b actual %0b",
                                 $time, oldest.mirroring_changed,
                                 i_out_data.mirroring_changed);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) apply_reg_write(i_cfg_data);
            if (i_in_valid && i_in_ready) begin
                map_access(i_in_data, want);
                pending_results.push_back(want);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_results.size();
    end

endmodule

### tb/testbench.sv
// testbench top: drives accesses and register writes into the mapper and gives the verdict
`timescale 1ns / 1ps

module testbench;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 140;
    localparam int NUM_PHASES    = 7;

    // op code the block treats as a no-op
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    lcbm_stream_if #(.t_payload(lcbm_pkg::t_in_item))   in_if ();
    lcbm_stream_if #(.t_payload(lcbm_pkg::t_out_item))  out_if ();
    lcbm_stream_if #(.t_payload(lcbm_pkg::t_cfg_write)) cfg_if ();

    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   results_seen;
    int   n_write, n_read, n_ppu, n_unused, n_cfg, n_settings;
    logic no_idle;
    logic hold_req;

    latched_chr_bank_mapper_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    lcbm_mapper_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_if.valid),
        .i_in_ready   (in_if.ready),
        .i_in_data    (in_if.data),
        .i_out_valid  (out_if.valid),
        .i_out_ready  (out_if.ready),
        .i_out_data   (out_if.data),
        .i_cfg_valid  (cfg_if.valid),
        .i_cfg_ready  (cfg_if.ready),
        .i_cfg_data   (cfg_if.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // watchdog on cycles with no transaction at all
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) results_seen <= results_seen + 1;
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("latched_chr_bank_mapper_core test failed");
                $finish;
            end
        end
    end

    // result receiver: random stalls, one long hold on request
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 4) == 0) begin
                    if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(10, 40);
                    else stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    // offer one access, leave valid high after the transaction
    task automatic send_access(input lcbm_pkg::t_in_item acc);
        int gap;
        int r;
        gap = 0;
        if (!no_idle) begin
            r = $urandom_range(0, 19);
            if (r >= 18) gap = $urandom_range(8, 30);
            else if (r >= 12) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= acc;
        do @(posedge i_clk); while (!in_if.ready);
        case (acc.op)
            lcbm_pkg::OP_CPU_WRITE: n_write++;
            lcbm_pkg::OP_CPU_READ:  n_read++;
            lcbm_pkg::OP_PPU_READ:  n_ppu++;
            default:                n_unused++;
        endcase
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lcbm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lcbm_pkg::COUNT_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= lcbm_pkg::t_cfg_write'{reg_index: idx, wdata: val};
        do @(posedge i_clk); while (!cfg_if.ready);
        n_cfg++;
    endtask

    task automatic configure(input logic [lcbm_pkg::COUNT_W-1:0] prg,
                             input logic [lcbm_pkg::COUNT_W-1:0] chr,
                             input logic hdr, input logic [lcbm_pkg::COUNT_W-1:0] dly);
        write_reg(lcbm_pkg::CFG_PRG_COUNT, prg);
        write_reg(lcbm_pkg::CFG_CHR_COUNT, chr);
        write_reg(lcbm_pkg::CFG_HDR_MIRROR, {8'd0, hdr});
        write_reg(lcbm_pkg::CFG_UPPER_DELAY, dly);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    // random access, weighted toward bank writes and latch trigger tiles
    function automatic lcbm_pkg::t_in_item rand_access();
        lcbm_pkg::t_in_item acc;
        int                 k;
        logic [3:0]         nib;
        logic [8:0]         tile;
        acc.data    = 8'($urandom);
        acc.address = 16'($urandom);
        k = $urandom_range(0, 99);
        if (k < 25) begin
            acc.op = lcbm_pkg::OP_CPU_WRITE;
            if ($urandom_range(0, 9) < 8) nib = 4'(4'hA + $urandom_range(0, 5));
            else nib = 4'($urandom_range(0, 9));
            acc.address[15:12] = nib;
        end else if (k < 45) begin
            acc.op = lcbm_pkg::OP_CPU_READ;
        end else if (k < 95) begin
            acc.op = lcbm_pkg::OP_PPU_READ;
            case ($urandom_range(0, 3))
                0: tile = lcbm_pkg::TILE_LOWER_FD;
                1: tile = lcbm_pkg::TILE_LOWER_FE;
                2: tile = lcbm_pkg::TILE_UPPER_FD;
                default: tile = lcbm_pkg::TILE_UPPER_FE;
            endcase
            if ($urandom_range(0, 2) == 0) acc.address[12:4] = tile;
            if ($urandom_range(0, 4) != 0) acc.address[15:13] = 3'b000;
        end else begin
            acc.op = OP_RESERVED;
        end
        return acc;
    endfunction

    // stimulus
    initial begin : stimulus
        logic [lcbm_pkg::COUNT_W-1:0] prg, chr, dly;
        logic                         hdr;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        no_idle      = 1'b0;
        hold_req     = 1'b0;
        idle_cycles  = 0;
        results_seen = 0;
        n_write = 0; n_read = 0; n_ppu = 0; n_unused = 0; n_cfg = 0; n_settings = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: header mirroring before any $F000 write, all windows and tiles
        configure(9'd5, 9'd12, 1'b1, 9'd2);
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_READ,  16'h8000, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_READ,  16'hFFFF, 8'hFF});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_READ,  16'h7FFF, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_WRITE, 16'hA000, 8'hFE});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_READ,  16'hBFFF, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_READ,  16'hC000, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_WRITE, 16'hB123, 8'hFF});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_WRITE, 16'hC000, 8'h07});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_WRITE, 16'hD000, 8'h0A});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_WRITE, 16'hEFFF, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_PPU_READ,  16'h0000, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_PPU_READ,  16'h0FE5, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_PPU_READ,  16'h0FD0, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_PPU_READ,  16'h1FE0, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_PPU_READ,  16'h1234, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_PPU_READ,  16'h1FFF, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_PPU_READ,  16'hFFD3, 8'hFF});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_WRITE, 16'h9000, 8'h55});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_WRITE, 16'h0000, 8'hFF});
        send_access(lcbm_pkg::t_in_item'{OP_RESERVED,            16'hFFFF, 8'hFF});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_WRITE, 16'hF000, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_WRITE, 16'hF001, 8'hFF});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_READ,  16'h4000, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_PPU_READ,  16'h0FE0, 8'h00});
        send_access(lcbm_pkg::t_in_item'{lcbm_pkg::OP_CPU_WRITE, 16'hB000, 8'h80});
        drain();

        // random phases over several register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin prg = 9'd1;   chr = 9'd1;   hdr = 1'b0; dly = 9'd1;   end
                1: begin prg = 9'd256; chr = 9'd256; hdr = 1'b1; dly = 9'd255; end
                2: begin prg = 9'd0;   chr = 9'd0;   hdr = 1'b0; dly = 9'd0;   end
                3: begin prg = 9'd511; chr = 9'd300; hdr = 1'b1; dly = 9'd128; end
                4: begin prg = 9'd8;   chr = 9'd16;  hdr = 1'b0; dly = 9'd1;   end
                default: begin
                    prg = 9'($urandom_range(1, 256));
                    chr = 9'($urandom_range(1, 256));
                    hdr = 1'($urandom);
                    dly = 9'($urandom_range(1, 255));
                end
            endcase
            configure(prg, chr, hdr, dly);
            no_idle = (p == 4);
            if (p == 2) hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_access(rand_access());
            drain();
        end
        no_idle = 1'b0;

        $display("covered %0d accesses: %0d cpu writes, %0d cpu reads, %0d pattern reads,",
                 n_write + n_read + n_ppu + n_unused, n_write, n_read, n_ppu);
        $display("%0d unused op, %0d register writes over %0d settings, %0d results checked",
                 n_unused, n_cfg, n_settings, results_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("latched_chr_bank_mapper_core test passed");
        end else begin
            $display("latched_chr_bank_mapper_core test failed");
        end
        $finish;
    end

endmodule

### latched_chr_bank_mapper_core.f
+incdir+sv
sv/lcbm_pkg.sv
sv/lcbm_stream_if.sv
sv/lcbm_mod_unit.sv
sv/latched_chr_bank_mapper_core.sv
tb/lcbm_mapper_checker.sv
tb/testbench.sv
